// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each check is clocked on i_clk and
// held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on every rising clock edge.
`define PCV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication from a trigger to a consequence in the next cycle.
`define PCV_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pcv_pkg.sv -----
`default_nettype none

package pcv_pkg;

    // Field widths
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CLEN_W    = 9;
    localparam int CKSUM_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Default maximum packet length in bytes
    localparam int PCV_MAX_BYTES = 512;

    // Header length and longest reported payload count
    localparam int HDR_BYTES = 4;
    localparam int CLEN_MAX  = (1 << CLEN_W) - 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 2'd1;

    // Verdict codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_CKSUM_BAD = 3'd1,
        ST_SEQ_BAD   = 3'd2,
        ST_TYPE_BAD  = 3'd3,
        ST_TOO_SHORT = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    // One verdict word
    typedef struct packed {
        t_status              status;
        logic [DATA_W-1:0]    received_seq;
        logic [DATA_W-1:0]    received_type;
        logic [CLEN_W-1:0]    payload_len;
        logic [CKSUM_W-1:0]   stored_checksum;
        logic [CKSUM_W-1:0]   computed_checksum;
    } t_verdict;

    // Ones'-complement 16-bit add with end-around carry
    function automatic logic [CKSUM_W-1:0] oc_add(input logic [CKSUM_W-1:0] a,
                                                  input logic [CKSUM_W-1:0] b);
        logic [CKSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CKSUM_W-1:0] + {{(CKSUM_W-1){1'b0}}, s[CKSUM_W]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pcv_byte_if.sv -----
`default_nettype none

// Packet byte stream
interface pcv_byte_if import pcv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcv_verdict_if.sv -----
`default_nettype none

// Per-packet verdict stream
interface pcv_verdict_if import pcv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   received_seq;
    logic [DATA_W-1:0]   received_type;
    logic [CLEN_W-1:0]   payload_len;
    logic [CKSUM_W-1:0]  stored_checksum;
    logic [CKSUM_W-1:0]  computed_checksum;

    modport source (output valid, output status, output received_seq,
                    output received_type, output payload_len,
                    output stored_checksum, output computed_checksum, input ready);
    modport sink   (input valid, input status, input received_seq,
                    input received_type, input payload_len,
                    input stored_checksum, input computed_checksum, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcv_cfg_if.sv -----
`default_nettype none

// Register write channel
interface pcv_cfg_if import pcv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/packet_checksum_verifier.sv -----
// Channel     Dir  Payload                                    Accepted when
// i_byte      in   data_byte[7:0], last_byte                  valid & ready
// o_verdict   out  status, seq, type, length, stored/computed valid & ready
// i_cfg       in   index[1:0], data[7:0]                      valid (ready tied high)
//
// One byte per cycle while no verdict waits on a stalled sink. A verdict appears in the
// output register the cycle after the last byte is taken; the packet state updates through oc_add.
// i_rst_n is synchronous, active low; it clears packet state, expected
// values and the output valid. While a verdict waits on a stalled sink,
// input bytes are held off; a byte is taken again in the cycle the verdict is.
`default_nettype none

module packet_checksum_verifier import pcv_pkg::*; #(
    parameter int MAX_BYTES = PCV_MAX_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pcv_byte_if.sink        i_byte,
    pcv_verdict_if.source   o_verdict,
    pcv_cfg_if.sink         i_cfg
);

    // Position counter and total length widths
    localparam int PW    = $clog2(MAX_BYTES);
    localparam int TW    = $clog2(MAX_BYTES + 1);
    localparam int EXT_W = (TW > CLEN_W + 1) ? TW : CLEN_W + 1;

    // Packet state
    logic [PW-1:0]      r_pos,      n_pos;
    logic [CKSUM_W-1:0] r_sum,      n_sum;
    logic [DATA_W-1:0]  r_pend,     n_pend;
    logic [DATA_W-1:0]  r_hdr_type, n_hdr_type;
    logic [DATA_W-1:0]  r_hdr_seq,  n_hdr_seq;
    logic [CKSUM_W-1:0] r_hdr_ck,   n_hdr_ck;
    logic               r_ovf,      n_ovf;

    // Expected header values
    logic [DATA_W-1:0]  r_exp_seq;
    logic [DATA_W-1:0]  r_exp_type;

    // Output register
    logic               r_out_valid;
    t_verdict           r_out;
    t_verdict           n_out;

    logic               in_acc;
    logic               in_last;
    logic [DATA_W-1:0]  word_byte;
    logic [TW-1:0]      total;
    logic [EXT_W-1:0]   clen_full;
    logic [CKSUM_W-1:0] comp;

    assign i_byte.ready = !r_out_valid || o_verdict.ready;
    assign in_acc       = i_byte.valid && i_byte.ready;
    assign in_last      = i_byte.last_byte;
    assign i_cfg.ready  = 1'b1;

    // Next packet state for the incoming byte
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_pend     = r_pend;
        n_hdr_type = r_hdr_type;
        n_hdr_seq  = r_hdr_seq;
        n_hdr_ck   = r_hdr_ck;
        n_ovf      = r_ovf;
        word_byte  = i_byte.data_byte;
        if (!r_ovf) begin
            if (r_pos == PW'(0)) n_hdr_type = i_byte.data_byte;
            if (r_pos == PW'(1)) n_hdr_seq  = i_byte.data_byte;
            if (r_pos == PW'(2)) begin
                n_hdr_ck[DATA_W-1:0] = i_byte.data_byte;
                word_byte = '0;
            end
            if (r_pos == PW'(3)) begin
                n_hdr_ck[CKSUM_W-1:DATA_W] = i_byte.data_byte;
                word_byte = '0;
            end
            // Low byte waits; high byte completes the word
            if (!r_pos[0]) begin
                n_pend = word_byte;
                if (in_last) n_sum = oc_add(r_sum, {{DATA_W{1'b0}}, word_byte});
            end else begin
                n_sum  = oc_add(r_sum, {word_byte, r_pend});
                n_pend = '0;
            end
            if (!in_last) begin
                if (r_pos == PW'(MAX_BYTES - 1)) n_ovf = 1'b1;
                else                             n_pos = r_pos + PW'(1);
            end
        end
    end

    // Verdict for a packet ending on this byte
    always_comb begin
        total     = TW'(r_pos) + TW'(1);
        clen_full = EXT_W'(total) - EXT_W'(HDR_BYTES);
        comp      = ~n_sum;
        n_out.received_seq      = n_hdr_seq;
        n_out.received_type     = n_hdr_type;
        n_out.stored_checksum   = n_hdr_ck;
        n_out.payload_len       = '0;
        n_out.computed_checksum = '0;
        if (r_ovf) begin
            n_out.status = ST_TOO_LONG;
        end else if (total < TW'(HDR_BYTES)) begin
            n_out.status = ST_TOO_SHORT;
        end else begin
            n_out.computed_checksum = comp;
            if (clen_full > EXT_W'(CLEN_MAX)) n_out.payload_len = CLEN_W'(CLEN_MAX);
            else                              n_out.payload_len = clen_full[CLEN_W-1:0];
            if (comp != n_hdr_ck)             n_out.status = ST_CKSUM_BAD;
            else if (n_hdr_seq != r_exp_seq)  n_out.status = ST_SEQ_BAD;
            else if (n_hdr_type != r_exp_type) n_out.status = ST_TYPE_BAD;
            else                              n_out.status = ST_OK;
        end
    end

    // Packet state registers; cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && in_last)) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_pend     <= '0;
            r_hdr_type <= '0;
            r_hdr_seq  <= '0;
            r_hdr_ck   <= '0;
            r_ovf      <= 1'b0;
        end else if (in_acc) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_pend     <= n_pend;
            r_hdr_type <= n_hdr_type;
            r_hdr_seq  <= n_hdr_seq;
            r_hdr_ck   <= n_hdr_ck;
            r_ovf      <= n_ovf;
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq  <= '0;
            r_exp_type <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_EXPECTED_SEQ:  r_exp_seq  <= i_cfg.data;
                CFG_EXPECTED_TYPE: r_exp_type <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (in_acc && in_last) begin
            r_out <= n_out;
        end
    end

    assign o_verdict.valid             = r_out_valid;
    assign o_verdict.status            = r_out.status;
    assign o_verdict.received_seq      = r_out.received_seq;
    assign o_verdict.received_type     = r_out.received_type;
    assign o_verdict.payload_len       = r_out.payload_len;
    assign o_verdict.stored_checksum   = r_out.stored_checksum;
    assign o_verdict.computed_checksum = r_out.computed_checksum;

`include "assert_macros.svh"

    `PCV_ASSERT_NEXT(a_clear_after_last, in_acc && in_last, r_pos == '0 && !r_ovf && r_sum == '0, "packet state not cleared after last byte")
    `PCV_ASSERT_NEXT(a_verdict_after_last, in_acc && in_last, r_out_valid, "no verdict after last byte")
    `PCV_ASSERT(a_ovf_at_end, !r_ovf || r_pos == PW'(MAX_BYTES - 1), "overflow set away from final position")

endmodule

`default_nettype wire
